FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/cfsp_pkg.sv
// ----------------------------------------------------------------------------
// Class file stream parser package
// Types and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package cfsp_pkg;
    localparam int POOL_DEPTH_DEFAULT = 4096;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] K_BAD_MAGIC = 4'd0;
    localparam logic [3:0] K_CAP_ERR   = 4'd1;
    localparam logic [3:0] K_MINOR     = 4'd2;
    localparam logic [3:0] K_MAJOR     = 4'd3;
    localparam logic [3:0] K_PCOUNT    = 4'd4;
    localparam logic [3:0] K_PENTRY    = 4'd5;
    localparam logic [3:0] K_TEXT      = 4'd6;
    localparam logic [3:0] K_UNK_TAG   = 4'd7;
    localparam logic [3:0] K_ACCESS    = 4'd8;
    localparam logic [3:0] K_MCOUNT    = 4'd11;
    localparam logic [3:0] K_MHEAD     = 4'd12;
    localparam logic [3:0] K_CHEAD     = 4'd13;
    localparam logic [3:0] K_CBYTE     = 4'd14;
    localparam logic [3:0] K_DONE      = 4'd15;

    localparam logic [31:0] MAGIC = 32'hCAFEBABE;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  tag;
        logic [15:0] index;
        logic [31:0] offset;
        logic [63:0] value;
    } t_event;

    localparam int EVENT_W = $bits(t_event);
endpackage

FILE: sv/cfsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module cfsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/cfsp_fifo.sv
// ----------------------------------------------------------------------------
// Event queue
// Short register queue that separates the parser from the result port.
// ----------------------------------------------------------------------------
module cfsp_fifo
    import cfsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    output logic   o_full,
    output logic   o_empty,
    input  logic   i_pop,
    output t_event o_data
);
    localparam int AW = $clog2(DEPTH);

    t_event          r_buf [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_buf[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_do_push) - (AW+1)'(w_do_pop);
        end
    end
endmodule

FILE: sv/cfsp_parser.sv
// ----------------------------------------------------------------------------
// Class file parser core
// Consumes one byte per cycle, walks the class file structure and produces
// at most one event per byte. The Code-name flag store is a RAM whose
// registered read lines up with the last byte of an attribute header.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cfsp_parser
    import cfsp_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ev_valid,
    output t_event     o_ev
);
    localparam int PW = $clog2(POOL_DEPTH);

    typedef enum logic [27:0] {
        S_MAGIC   = 28'd1 << 0,  S_VERS    = 28'd1 << 1,  S_PCOUNT  = 28'd1 << 2,
        S_PTAG    = 28'd1 << 3,  S_PBODY   = 28'd1 << 4,  S_PTEXT   = 28'd1 << 5,
        S_CLSHDR  = 28'd1 << 6,  S_ISKIP   = 28'd1 << 7,  S_FCOUNT  = 28'd1 << 8,
        S_FHEAD   = 28'd1 << 9,  S_FAHEAD  = 28'd1 << 10, S_FASKIP  = 28'd1 << 11,
        S_MCOUNT  = 28'd1 << 12, S_MHEAD   = 28'd1 << 13, S_MACOUNT = 28'd1 << 14,
        S_MAHEAD  = 28'd1 << 15, S_MASKIP  = 28'd1 << 16, S_CHEAD   = 28'd1 << 17,
        S_CBYTES  = 28'd1 << 18, S_ETCOUNT = 28'd1 << 19, S_ETSKIP  = 28'd1 << 20,
        S_CACOUNT = 28'd1 << 21, S_CAHEAD  = 28'd1 << 22, S_CASKIP  = 28'd1 << 23,
        S_KACOUNT = 28'd1 << 24, S_KAHEAD  = 28'd1 << 25, S_KASKIP  = 28'd1 << 26,
        S_HALT    = 28'd1 << 27
    } t_state;

    t_state       r_st, n_st;
    logic [2:0]   r_bpos, n_bpos;
    logic [63:0]  r_acc, n_acc;
    logic [16:0]  r_psize, n_psize;
    logic [16:0]  r_pcur, n_pcur;
    logic [31:0]  r_len, n_len;
    logic [7:0]   r_tag, n_tag;
    logic [15:0]  r_gtot, n_gtot, r_gcur, n_gcur;
    logic [15:0]  r_atot, n_atot, r_acur, n_acur;
    logic [15:0]  r_itot, n_itot, r_icur, n_icur;
    logic [31:0]  r_cpos, n_cpos;
    logic [2:0]   r_match, n_match;
    logic         r_nm_ok;

    logic         w_we, w_wd, w_rd;
    logic [PW-1:0] w_waddr, w_raddr;
    logic [63:0]  w_v;
    logic [2:0]   w_n, w_w;
    logic [15:0]  w_lo16, w_nm;
    logic [31:0]  w_lo32;
    t_event       w_ev;
    logic         w_evv;

    cfsp_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_flags (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wd),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    // The name index sits in bytes one and two of the six-byte header, so
    // the read address is ready on the fifth byte and held while the sixth
    // byte is awaited.
    assign w_nm    = (r_bpos == 3'd5) ? r_acc[39:24] : r_acc[31:16];
    assign w_raddr = w_nm[PW-1:0];

    function automatic logic [2:0] f_body_w(input logic [7:0] t);
        case (t)
            8'd1, 8'd7, 8'd8, 8'd16: f_body_w = 3'd2;
            8'd15:                   f_body_w = 3'd3;
            8'd5, 8'd6:              f_body_w = 3'd0;
            default:                 f_body_w = 3'd4;
        endcase
    endfunction

    function automatic logic f_tag_ok(input logic [7:0] t);
        case (t)
            8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
            8'd15, 8'd16, 8'd18: f_tag_ok = 1'b1;
            default:             f_tag_ok = 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] f_code_ch(input logic [1:0] i);
        case (i)
            2'd0:    f_code_ch = 8'h43;
            2'd1:    f_code_ch = 8'h6F;
            2'd2:    f_code_ch = 8'h64;
            default: f_code_ch = 8'h65;
        endcase
    endfunction

    always_comb begin
        n_st = r_st; n_bpos = r_bpos; n_acc = r_acc; n_psize = r_psize;
        n_pcur = r_pcur; n_len = r_len; n_tag = r_tag; n_gtot = r_gtot;
        n_gcur = r_gcur; n_atot = r_atot; n_acur = r_acur; n_itot = r_itot;
        n_icur = r_icur; n_cpos = r_cpos; n_match = r_match;
        w_we = 1'b0; w_wd = 1'b0; w_waddr = r_pcur[PW-1:0];
        w_evv = 1'b0; w_ev = '0;
        w_v = {r_acc[55:0], i_byte};
        w_n = r_bpos + 3'd1;
        w_lo16 = w_v[15:0];
        w_lo32 = w_v[31:0];
        unique case (r_st)
            S_MAGIC, S_VERS:                   w_w = 3'd4;
            S_PBODY:                           w_w = f_body_w(r_tag);
            S_CLSHDR, S_FHEAD, S_CHEAD:        w_w = 3'd0;
            S_FAHEAD, S_MHEAD, S_MAHEAD, S_CAHEAD, S_KAHEAD: w_w = 3'd6;
            default:                           w_w = 3'd2;
        endcase
        if (i_valid) begin
            unique case (r_st)
                S_HALT: begin
                end
                S_PTAG: begin
                    w_we = (r_pcur < r_psize);
                    if (f_tag_ok(i_byte)) begin
                        n_tag = i_byte;
                        n_st = S_PBODY;
                    end else begin
                        w_evv = 1'b1;
                        w_ev = '{kind: K_UNK_TAG, tag: i_byte, index: r_pcur[15:0],
                                 offset: '0, value: '0};
                        n_pcur = r_pcur + 17'd1;
                        n_st = (n_pcur < r_psize) ? S_PTAG : S_CLSHDR;
                    end
                end
                S_PTEXT: begin
                    w_evv = 1'b1;
                    w_ev = '{kind: K_TEXT, tag: 8'd1, index: r_pcur[15:0],
                             offset: r_cpos, value: {56'd0, i_byte}};
                    if (r_cpos < 32'd4 && r_cpos[2:0] == r_match
                        && i_byte == f_code_ch(r_cpos[1:0])) begin
                        n_match = r_match + 3'd1;
                    end
                    n_cpos = r_cpos + 32'd1;
                    n_len = r_len - 32'd1;
                    if (n_len == '0) begin
                        w_we = (r_pcur < r_psize);
                        w_wd = (n_cpos == 32'd4) && (n_match == 3'd4);
                        n_pcur = r_pcur + 17'd1;
                        n_st = (n_pcur < r_psize) ? S_PTAG : S_CLSHDR;
                    end
                end
                S_CBYTES: begin
                    w_evv = 1'b1;
                    w_ev = '{kind: K_CBYTE, tag: '0, index: r_gcur, offset: r_cpos,
                             value: {56'd0, i_byte}};
                    n_cpos = r_cpos + 32'd1;
                    n_len = r_len - 32'd1;
                    if (n_len == '0) begin
                        n_st = S_ETCOUNT;
                    end
                end
                S_ISKIP, S_FASKIP, S_MASKIP, S_ETSKIP, S_CASKIP, S_KASKIP: begin
                    n_len = r_len - 32'd1;
                    if (n_len == '0) begin
                        unique case (r_st)
                            S_ISKIP:  n_st = S_FCOUNT;
                            S_ETSKIP: n_st = S_CACOUNT;
                            S_FASKIP: begin
                                n_acur = r_acur + 16'd1;
                                if (n_acur < r_atot) begin
                                    n_st = S_FAHEAD;
                                end else begin
                                    n_gcur = r_gcur + 16'd1;
                                    n_st = (n_gcur < r_gtot) ? S_FHEAD : S_MCOUNT;
                                end
                            end
                            S_MASKIP: begin
                                n_acur = r_acur + 16'd1;
                                if (n_acur < r_atot) begin
                                    n_st = S_MAHEAD;
                                end else begin
                                    n_gcur = r_gcur + 16'd1;
                                    n_st = (n_gcur < r_gtot) ? S_MHEAD : S_KACOUNT;
                                end
                            end
                            S_CASKIP: begin
                                n_icur = r_icur + 16'd1;
                                if (n_icur < r_itot) begin
                                    n_st = S_CAHEAD;
                                end else begin
                                    n_acur = r_acur + 16'd1;
                                    if (n_acur < r_atot) begin
                                        n_st = S_MAHEAD;
                                    end else begin
                                        n_gcur = r_gcur + 16'd1;
                                        n_st = (n_gcur < r_gtot) ? S_MHEAD : S_KACOUNT;
                                    end
                                end
                            end
                            default: begin
                                n_acur = r_acur + 16'd1;
                                if (n_acur < r_atot) begin
                                    n_st = S_KAHEAD;
                                end else begin
                                    w_evv = 1'b1;
                                    w_ev = '{kind: K_DONE, default: '0};
                                    n_st = S_HALT;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    n_acc = w_v;
                    if (w_n != w_w) begin
                        n_bpos = w_n;
                        if (r_st == S_VERS && w_n == 3'd2) begin
                            w_evv = 1'b1;
                            w_ev = '{kind: K_MINOR, value: {48'd0, w_lo16}, default: '0};
                        end else if (r_st == S_CLSHDR && (w_n == 3'd2 || w_n == 3'd4
                                     || w_n == 3'd6)) begin
                            w_evv = 1'b1;
                            w_ev = '{kind: K_ACCESS + {2'd0, w_n[2:1]} - 4'd1,
                                     value: {48'd0, w_lo16}, default: '0};
                        end
                    end else begin
                        n_bpos = '0;
                        n_acc = '0;
                        unique case (r_st)
                            S_MAGIC: begin
                                if (w_lo32 != MAGIC) begin
                                    w_evv = 1'b1;
                                    w_ev = '{kind: K_BAD_MAGIC, value: {32'd0, w_lo32},
                                             default: '0};
                                    n_st = S_HALT;
                                end else begin
                                    n_st = S_VERS;
                                end
                            end
                            S_VERS: begin
                                w_evv = 1'b1;
                                w_ev = '{kind: K_MAJOR, value: {48'd0, w_lo16}, default: '0};
                                n_st = S_PCOUNT;
                            end
                            S_PCOUNT: begin
                                w_evv = 1'b1;
                                if ({1'b0, w_lo16} > 17'(POOL_DEPTH)) begin
                                    w_ev = '{kind: K_CAP_ERR, value: {48'd0, w_lo16},
                                             default: '0};
                                    n_st = S_HALT;
                                end else begin
                                    w_ev = '{kind: K_PCOUNT, value: {48'd0, w_lo16},
                                             default: '0};
                                    n_psize = {1'b0, w_lo16};
                                    n_pcur = 17'd1;
                                    n_st = (17'd1 < n_psize) ? S_PTAG : S_CLSHDR;
                                end
                            end
                            S_PBODY: begin
                                w_evv = 1'b1;
                                w_ev = '{kind: K_PENTRY, tag: r_tag, index: r_pcur[15:0],
                                         offset: '0, value: w_v};
                                if (r_tag == 8'd1) begin
                                    n_match = '0;
                                    n_cpos = '0;
                                    if (w_lo16 == '0) begin
                                        n_pcur = r_pcur + 17'd1;
                                        n_st = (n_pcur < r_psize) ? S_PTAG : S_CLSHDR;
                                    end else begin
                                        n_len = {16'd0, w_lo16};
                                        n_st = S_PTEXT;
                                    end
                                end else if (r_tag == 8'd5 || r_tag == 8'd6) begin
                                    w_we = (r_pcur + 17'd1 < r_psize);
                                    w_waddr = PW'(r_pcur + 17'd1);
                                    n_pcur = (r_pcur + 17'd2 >= r_psize) ? r_psize
                                                                         : r_pcur + 17'd2;
                                    n_st = (n_pcur < r_psize) ? S_PTAG : S_CLSHDR;
                                end else begin
                                    n_pcur = r_pcur + 17'd1;
                                    n_st = (n_pcur < r_psize) ? S_PTAG : S_CLSHDR;
                                end
                            end
                            S_CLSHDR: begin
                                if (w_lo16 == '0) begin
                                    n_st = S_FCOUNT;
                                end else begin
                                    n_len = {15'd0, w_lo16, 1'b0};
                                    n_st = S_ISKIP;
                                end
                            end
                            S_FCOUNT: begin
                                n_gtot = w_lo16;
                                n_gcur = '0;
                                n_st = (w_lo16 != '0) ? S_FHEAD : S_MCOUNT;
                            end
                            S_FHEAD: begin
                                n_atot = w_lo16;
                                n_acur = '0;
                                if (w_lo16 != '0) begin
                                    n_st = S_FAHEAD;
                                end else begin
                                    n_gcur = r_gcur + 16'd1;
                                    n_st = (n_gcur < r_gtot) ? S_FHEAD : S_MCOUNT;
                                end
                            end
                            S_MCOUNT: begin
                                w_evv = 1'b1;
                                w_ev = '{kind: K_MCOUNT, value: {48'd0, w_lo16}, default: '0};
                                n_gtot = w_lo16;
                                n_gcur = '0;
                                n_st = (w_lo16 != '0) ? S_MHEAD : S_KACOUNT;
                            end
                            S_MHEAD: begin
                                w_evv = 1'b1;
                                w_ev = '{kind: K_MHEAD, tag: '0, index: r_gcur, offset: '0,
                                         value: w_v};
                                n_st = S_MACOUNT;
                            end
                            S_MACOUNT: begin
                                n_atot = w_lo16;
                                n_acur = '0;
                                if (w_lo16 != '0) begin
                                    n_st = S_MAHEAD;
                                end else begin
                                    n_gcur = r_gcur + 16'd1;
                                    n_st = (n_gcur < r_gtot) ? S_MHEAD : S_KACOUNT;
                                end
                            end
                            S_CHEAD: begin
                                w_evv = 1'b1;
                                w_ev = '{kind: K_CHEAD, tag: '0, index: r_gcur, offset: '0,
                                         value: w_v};
                                n_cpos = '0;
                                if (w_lo32 == '0) begin
                                    n_st = S_ETCOUNT;
                                end else begin
                                    n_len = w_lo32;
                                    n_st = S_CBYTES;
                                end
                            end
                            S_ETCOUNT: begin
                                if (w_lo16 == '0) begin
                                    n_st = S_CACOUNT;
                                end else begin
                                    n_len = {13'd0, w_lo16, 3'd0};
                                    n_st = S_ETSKIP;
                                end
                            end
                            S_CACOUNT: begin
                                n_itot = w_lo16;
                                n_icur = '0;
                                if (w_lo16 != '0) begin
                                    n_st = S_CAHEAD;
                                end else begin
                                    n_acur = r_acur + 16'd1;
                                    if (n_acur < r_atot) begin
                                        n_st = S_MAHEAD;
                                    end else begin
                                        n_gcur = r_gcur + 16'd1;
                                        n_st = (n_gcur < r_gtot) ? S_MHEAD : S_KACOUNT;
                                    end
                                end
                            end
                            S_KACOUNT: begin
                                n_atot = w_lo16;
                                n_acur = '0;
                                if (w_lo16 != '0) begin
                                    n_st = S_KAHEAD;
                                end else begin
                                    w_evv = 1'b1;
                                    w_ev = '{kind: K_DONE, default: '0};
                                    n_st = S_HALT;
                                end
                            end
                            S_MAHEAD: begin
                                if (r_nm_ok && w_rd) begin
                                    n_st = S_CHEAD;
                                end else if (w_lo32 != '0) begin
                                    n_len = w_lo32;
                                    n_st = S_MASKIP;
                                end else begin
                                    n_acur = r_acur + 16'd1;
                                    if (n_acur < r_atot) begin
                                        n_st = S_MAHEAD;
                                    end else begin
                                        n_gcur = r_gcur + 16'd1;
                                        n_st = (n_gcur < r_gtot) ? S_MHEAD : S_KACOUNT;
                                    end
                                end
                            end
                            S_FAHEAD: begin
                                if (w_lo32 != '0) begin
                                    n_len = w_lo32;
                                    n_st = S_FASKIP;
                                end else begin
                                    n_acur = r_acur + 16'd1;
                                    if (n_acur < r_atot) begin
                                        n_st = S_FAHEAD;
                                    end else begin
                                        n_gcur = r_gcur + 16'd1;
                                        n_st = (n_gcur < r_gtot) ? S_FHEAD : S_MCOUNT;
                                    end
                                end
                            end
                            S_CAHEAD: begin
                                if (w_lo32 != '0) begin
                                    n_len = w_lo32;
                                    n_st = S_CASKIP;
                                end else begin
                                    n_icur = r_icur + 16'd1;
                                    if (n_icur < r_itot) begin
                                        n_st = S_CAHEAD;
                                    end else begin
                                        n_acur = r_acur + 16'd1;
                                        if (n_acur < r_atot) begin
                                            n_st = S_MAHEAD;
                                        end else begin
                                            n_gcur = r_gcur + 16'd1;
                                            n_st = (n_gcur < r_gtot) ? S_MHEAD : S_KACOUNT;
                                        end
                                    end
                                end
                            end
                            default: begin
                                if (w_lo32 != '0) begin
                                    n_len = w_lo32;
                                    n_st = S_KASKIP;
                                end else begin
                                    n_acur = r_acur + 16'd1;
                                    if (n_acur < r_atot) begin
                                        n_st = S_KAHEAD;
                                    end else begin
                                        w_evv = 1'b1;
                                        w_ev = '{kind: K_DONE, default: '0};
                                        n_st = S_HALT;
                                    end
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_MAGIC; r_bpos <= '0; r_acc <= '0; r_psize <= '0; r_pcur <= '0;
            r_len <= '0; r_tag <= '0; r_gtot <= '0; r_gcur <= '0; r_atot <= '0;
            r_acur <= '0; r_itot <= '0; r_icur <= '0; r_cpos <= '0; r_match <= '0;
            r_nm_ok <= 1'b0; o_ev_valid <= 1'b0;
        end else begin
            r_st <= n_st; r_bpos <= n_bpos; r_acc <= n_acc; r_psize <= n_psize;
            r_pcur <= n_pcur; r_len <= n_len; r_tag <= n_tag; r_gtot <= n_gtot;
            r_gcur <= n_gcur; r_atot <= n_atot; r_acur <= n_acur; r_itot <= n_itot;
            r_icur <= n_icur; r_cpos <= n_cpos; r_match <= n_match;
            r_nm_ok <= (w_nm != '0) && ({1'b0, w_nm} < r_psize);
            o_ev_valid <= w_evv;
        end
    end

    always_ff @(posedge i_clk) begin
        o_ev <= w_ev;
    end

    `ASSERT_IMPL(a_halt_stays, i_clk, i_rst_n, (r_st == S_HALT) |=> (r_st == S_HALT), "halt left")
    `ASSERT_IMPL(a_cursor_bound, i_clk, i_rst_n, (r_pcur <= r_psize) || (r_st == S_MAGIC) || (r_st == S_VERS) || (r_st == S_PCOUNT) || (r_st == S_HALT), "pool cursor past size")
    `ASSERT_NEXT(a_halt_silent, i_clk, i_rst_n, (r_st == S_HALT), !o_ev_valid, "event after halt")
endmodule

FILE: sv/class_file_stream_parser.sv
// ----------------------------------------------------------------------------
// Class file stream parser
// Streams a class file one byte per transaction and emits parse events.
//
// Channel   Direction  Handshake       Payload
// input     in         i_push / o_full  i_data_byte
// result    out        o_empty / i_pop  o_kind o_tag o_index o_offset o_value
//
// The parser handles each accepted byte without stalling; its event is registered
// at the parser output, then written into the event queue and shown on the result ports from its head.
// The flag store is read one byte ahead of the attribute name check.
// Reset is synchronous; the flag store needs no clearing pass.
// o_full rises when the event queue cannot absorb the events in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module class_file_stream_parser
    import cfsp_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_tag,
    output logic [15:0] o_index,
    output logic [31:0] o_offset,
    output logic [63:0] o_value
);
    logic   w_acc, w_evv, w_qfull, w_pop;
    t_event w_ev, w_q;
    logic [2:0] r_cnt;
    logic       r_slot;

    // Credit count: events in the queue plus the byte held in the parser register.
    assign o_full = (r_cnt >= 3'(QUEUE_DEPTH));
    assign w_acc  = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_slot <= 1'b0;
        end else begin
            r_slot <= w_acc;
            r_cnt  <= r_cnt + 3'(w_acc) - 3'(r_slot && !w_evv) - 3'(w_pop);
        end
    end

    cfsp_parser #(.POOL_DEPTH(POOL_DEPTH)) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_acc),
        .i_byte    (i_data_byte),
        .o_ev_valid(w_evv),
        .o_ev      (w_ev)
    );

    cfsp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_evv),
        .i_data (w_ev),
        .o_full (w_qfull),
        .o_empty(o_empty),
        .i_pop  (i_pop),
        .o_data (w_q)
    );

    assign o_kind   = w_q.kind;
    assign o_tag    = w_q.tag;
    assign o_index  = w_q.index;
    assign o_offset = w_q.offset;
    assign o_value  = w_q.value;

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, !(w_evv && w_qfull), "event queue overflow")
endmodule

FILE: sim/class_file_stream_parser_test.sv
// ----------------------------------------------------------------------------
// Class file stream parser testbench
// Streams one generated class file through the parser with random push and
// pop gaps, predicts every event, and compares each popped event field by
// field with the oldest predicted one.
// ----------------------------------------------------------------------------
module class_file_stream_parser_test;
    import cfsp_pkg::*;

    localparam int DEPTH = POOL_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [4:0] {
        PH_MAGIC, PH_VERS, PH_PCOUNT, PH_PTAG, PH_PBODY, PH_PTEXT, PH_CLSHDR,
        PH_ISKIP, PH_FCOUNT, PH_FHEAD, PH_FAHEAD, PH_FASKIP, PH_MCOUNT, PH_MHEAD,
        PH_MACOUNT, PH_MAHEAD, PH_MASKIP, PH_CHEAD, PH_CBYTES, PH_ETCOUNT,
        PH_ETSKIP, PH_CACOUNT, PH_CAHEAD, PH_CASKIP, PH_KACOUNT, PH_KAHEAD,
        PH_KASKIP, PH_HALT
    } parse_phase_t;

    localparam logic [7:0] TAG_UTF8 = 8'd1;
    localparam logic [7:0] TAG_INT  = 8'd3;
    localparam logic [7:0] TAG_LONG = 8'd5;
    localparam logic [7:0] TAG_DBL  = 8'd6;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [7:0]  i_data_byte;
    logic        o_empty;
    logic        i_pop;
    logic [3:0]  o_kind;
    logic [7:0]  o_tag;
    logic [15:0] o_index;
    logic [31:0] o_offset;
    logic [63:0] o_value;

    class_file_stream_parser u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_data_byte(i_data_byte), .o_empty(o_empty), .i_pop(i_pop),
        .o_kind(o_kind), .o_tag(o_tag), .o_index(o_index),
        .o_offset(o_offset), .o_value(o_value)
    );

    // Parser state as the predictor sees it.
    parse_phase_t phase;
    int unsigned  field_pos;
    logic [63:0]  field_acc;
    int unsigned  pool_size, pool_cur, remaining;
    int unsigned  grp_total, grp_cur, attr_total, attr_cur, inner_total, inner_cur;
    int unsigned  code_pos, name_match;
    bit           code_flag [DEPTH];

    t_event       expected_events [$];
    logic [7:0]   file_bytes [$];
    logic [7:0]   gen_bytes [$];
    int unsigned  code_slots [$];
    int unsigned  errors;
    int unsigned  cycles;
    int unsigned  rx_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function void emit(logic [3:0] k, logic [7:0] t, int unsigned idx, int unsigned ofs,
                       logic [63:0] v);
        t_event e;
        e.kind = k;
        e.tag = t;
        e.index = idx[15:0];
        e.offset = ofs;
        e.value = v;
        expected_events.push_back(e);
    endfunction

    function void set_flag(int unsigned slot, bit v);
        if (slot < pool_size && slot < DEPTH) code_flag[slot] = v;
    endfunction

    function void pool_next();
        phase = (pool_cur < pool_size) ? PH_PTAG : PH_CLSHDR;
    endfunction

    function void pool_advance(int unsigned step);
        int unsigned nx;
        nx = pool_cur + step;
        if (step == 2) set_flag(pool_cur + 1, 1'b0);
        pool_cur = (nx >= pool_size) ? pool_size : nx;
        pool_next();
    endfunction

    function void field_next();
        phase = (grp_cur < grp_total) ? PH_FHEAD : PH_MCOUNT;
    endfunction

    function void field_attr_next();
        if (attr_cur < attr_total) begin
            phase = PH_FAHEAD;
        end else begin
            grp_cur++;
            field_next();
        end
    endfunction

    function void method_next();
        phase = (grp_cur < grp_total) ? PH_MHEAD : PH_KACOUNT;
    endfunction

    function void method_attr_next();
        if (attr_cur < attr_total) begin
            phase = PH_MAHEAD;
        end else begin
            grp_cur++;
            method_next();
        end
    endfunction

    function void inner_next();
        if (inner_cur < inner_total) begin
            phase = PH_CAHEAD;
        end else begin
            attr_cur++;
            method_attr_next();
        end
    endfunction

    function void class_attr_next();
        if (attr_cur < attr_total) begin
            phase = PH_KAHEAD;
        end else begin
            emit(K_DONE, 0, 0, 0, 0);
            phase = PH_HALT;
        end
    endfunction

    function void skip_end(parse_phase_t ph);
        case (ph)
            PH_ISKIP: phase = PH_FCOUNT;
            PH_FASKIP: begin
                attr_cur++;
                field_attr_next();
            end
            PH_MASKIP: begin
                attr_cur++;
                method_attr_next();
            end
            PH_ETSKIP: phase = PH_CACOUNT;
            PH_CASKIP: begin
                inner_cur++;
                inner_next();
            end
            default: begin
                attr_cur++;
                class_attr_next();
            end
        endcase
    endfunction

    function void begin_skip(parse_phase_t ph, int unsigned len);
        if (len == 0) begin
            skip_end(ph);
        end else begin
            remaining = len;
            phase = ph;
        end
    endfunction

    function bit is_pool_tag(logic [7:0] t);
        case (t)
            1, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 15, 16, 18: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function int unsigned body_width(logic [7:0] t);
        case (t)
            1, 7, 8, 16: return 2;
            15: return 3;
            5, 6: return 8;
            default: return 4;
        endcase
    endfunction

    function int unsigned field_width();
        case (phase)
            PH_MAGIC, PH_VERS: return 4;
            PH_PBODY: return body_width(remaining[7:0]);
            PH_CLSHDR, PH_FHEAD, PH_CHEAD: return 8;
            PH_FAHEAD, PH_MHEAD, PH_MAHEAD, PH_CAHEAD, PH_KAHEAD: return 6;
            default: return 2;
        endcase
    endfunction

    function logic [7:0] code_char(int unsigned i);
        case (i)
            0: return "C";
            1: return "o";
            2: return "d";
            default: return "e";
        endcase
    endfunction

    function void field_done(logic [63:0] v);
        int unsigned lo16, lo32, nm;
        logic [7:0] t;
        lo16 = v[15:0];
        lo32 = v[31:0];
        case (phase)
            PH_MAGIC: begin
                if (v[31:0] != MAGIC) begin
                    emit(K_BAD_MAGIC, 0, 0, 0, lo32);
                    phase = PH_HALT;
                end else begin
                    phase = PH_VERS;
                end
            end
            PH_VERS: begin
                emit(K_MAJOR, 0, 0, 0, lo16);
                phase = PH_PCOUNT;
            end
            PH_PCOUNT: begin
                if (lo16 > DEPTH) begin
                    emit(K_CAP_ERR, 0, 0, 0, lo16);
                    phase = PH_HALT;
                end else begin
                    emit(K_PCOUNT, 0, 0, 0, lo16);
                    pool_size = lo16;
                    pool_cur = 1;
                    pool_next();
                end
            end
            PH_PBODY: begin
                t = remaining[7:0];
                emit(K_PENTRY, t, pool_cur, 0, v);
                if (t == TAG_UTF8) begin
                    name_match = 0;
                    code_pos = 0;
                    if (lo16 == 0) begin
                        set_flag(pool_cur, 1'b0);
                        pool_advance(1);
                    end else begin
                        remaining = lo16;
                        phase = PH_PTEXT;
                    end
                end else begin
                    pool_advance((t == TAG_LONG || t == TAG_DBL) ? 2 : 1);
                end
            end
            PH_CLSHDR: begin_skip(PH_ISKIP, lo16 * 2);
            PH_FCOUNT: begin
                grp_total = lo16;
                grp_cur = 0;
                field_next();
            end
            PH_FHEAD: begin
                attr_total = lo16;
                attr_cur = 0;
                field_attr_next();
            end
            PH_FAHEAD: begin_skip(PH_FASKIP, lo32);
            PH_MCOUNT: begin
                emit(K_MCOUNT, 0, 0, 0, lo16);
                grp_total = lo16;
                grp_cur = 0;
                method_next();
            end
            PH_MHEAD: begin
                emit(K_MHEAD, 0, grp_cur, 0, v);
                phase = PH_MACOUNT;
            end
            PH_MACOUNT: begin
                attr_total = lo16;
                attr_cur = 0;
                method_attr_next();
            end
            PH_MAHEAD: begin
                nm = v[47:32];
                if (nm != 0 && nm < pool_size && nm < DEPTH && code_flag[nm]) begin
                    phase = PH_CHEAD;
                end else begin
                    begin_skip(PH_MASKIP, lo32);
                end
            end
            PH_CHEAD: begin
                emit(K_CHEAD, 0, grp_cur, 0, v);
                code_pos = 0;
                if (lo32 == 0) begin
                    phase = PH_ETCOUNT;
                end else begin
                    remaining = lo32;
                    phase = PH_CBYTES;
                end
            end
            PH_ETCOUNT: begin_skip(PH_ETSKIP, lo16 * 8);
            PH_CACOUNT: begin
                inner_total = lo16;
                inner_cur = 0;
                inner_next();
            end
            PH_CAHEAD: begin_skip(PH_CASKIP, lo32);
            PH_KACOUNT: begin
                attr_total = lo16;
                attr_cur = 0;
                class_attr_next();
            end
            default: begin_skip(PH_KASKIP, lo32);
        endcase
    endfunction

    function void parse_byte(logic [7:0] b);
        int unsigned n;
        logic [63:0] v;
        case (phase)
            PH_HALT: ;
            PH_PTAG: begin
                set_flag(pool_cur, 1'b0);
                if (is_pool_tag(b)) begin
                    remaining = b;
                    phase = PH_PBODY;
                end else begin
                    emit(K_UNK_TAG, b, pool_cur, 0, 0);
                    pool_advance(1);
                end
            end
            PH_PTEXT: begin
                emit(K_TEXT, TAG_UTF8, pool_cur, code_pos, b);
                if (code_pos < 4 && name_match == code_pos && b == code_char(code_pos))
                    name_match++;
                code_pos++;
                remaining--;
                if (remaining == 0) begin
                    set_flag(pool_cur, code_pos == 4 && name_match == 4);
                    pool_advance(1);
                end
            end
            PH_CBYTES: begin
                emit(K_CBYTE, 0, grp_cur, code_pos, b);
                code_pos++;
                remaining--;
                if (remaining == 0) phase = PH_ETCOUNT;
            end
            PH_ISKIP, PH_FASKIP, PH_MASKIP, PH_ETSKIP, PH_CASKIP, PH_KASKIP: begin
                remaining--;
                if (remaining == 0) skip_end(phase);
            end
            default: begin
                field_acc = (field_acc << 8) | b;
                n = field_pos + 1;
                if (n < field_width()) begin
                    field_pos = n;
                    if (phase == PH_VERS && n == 2)
                        emit(K_MINOR, 0, 0, 0, field_acc[15:0]);
                    else if (phase == PH_CLSHDR && (n == 2 || n == 4 || n == 6))
                        emit(K_ACCESS + 4'(n / 2 - 1), 0, 0, 0, field_acc[15:0]);
                end else begin
                    v = field_acc;
                    field_pos = 0;
                    field_acc = 0;
                    field_done(v);
                end
            end
        endcase
    endfunction

    function void put8(logic [7:0] b);
        gen_bytes.push_back(b);
    endfunction

    function void put16(int unsigned v);
        put8(v[15:8]);
        put8(v[7:0]);
    endfunction

    function void put32(int unsigned v);
        put16(v >> 16);
        put16(v & 32'hFFFF);
    endfunction

    function void put_random(int unsigned n);
        repeat (n) put8($urandom_range(0, 255));
    endfunction

    function void flush_bytes();
        foreach (gen_bytes[i]) file_bytes.push_back(gen_bytes[i]);
        gen_bytes.delete();
    endfunction

    function void add_text(string s, int unsigned slot);
        put8(TAG_UTF8);
        put16(s.len());
        for (int i = 0; i < s.len(); i++) put8(s[i]);
        if (s == "Code") code_slots.push_back(slot);
    endfunction

    function int unsigned add_tag(logic [7:0] t);
        put8(t);
        if (!is_pool_tag(t)) return 1;
        put_random(body_width(t));
        return (t == TAG_LONG || t == TAG_DBL) ? 2 : 1;
    endfunction

    function bit names_code(int unsigned nm);
        foreach (code_slots[i]) if (code_slots[i] == nm) return 1'b1;
        return 1'b0;
    endfunction

    function int unsigned pick_name();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return code_slots[$urandom_range(0, code_slots.size() - 1)];
            5: return 0;
            6: return $urandom_range(2, 4);
            7: return $urandom_range(1, pool_size - 1);
            8: return pool_size + $urandom_range(0, 3);
            default: return 16'hFFFF;
        endcase
    endfunction

    function void add_skipped_attrs(int unsigned count, int unsigned max_len);
        int unsigned len;
        for (int i = 0; i < count; i++) begin
            len = $urandom_range(0, max_len);
            put16($urandom_range(0, 16'hFFFF));
            put32(len);
            put_random(len);
        end
    endfunction

    function void build_class_file();
        int unsigned slot, target, cnt, nm, len, k;
        logic [7:0] t;
        logic [7:0] directed_tags [$];
        logic [7:0] valid_tags [$];

        directed_tags = '{3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 15, 16, 18, 0, 2, 13, 255};
        valid_tags = '{1, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 15, 16, 18};

        put32(MAGIC);
        put16(16'h0000);
        put16(16'hFFFF);
        flush_bytes();

        add_text("Code", 1);
        add_text("Cod", 2);
        add_text("Codf", 3);
        add_text("Codex", 4);
        add_text("", 5);
        slot = 6;
        foreach (directed_tags[i]) slot += add_tag(directed_tags[i]);
        target = slot + $urandom_range(20, 40);
        while (slot < target - 1) begin
            k = $urandom_range(0, 9);
            if (k < 3) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_text("Code", slot);
                end else begin
                    len = $urandom_range(1, 6);
                    put8(TAG_UTF8);
                    put16(len);
                    put_random(len);
                end
                slot++;
            end else begin
                t = (k < 4) ? 8'($urandom_range(0, 255))
                            : valid_tags[$urandom_range(1, valid_tags.size() - 1)];
                if (slot == target - 2 && (t == TAG_LONG || t == TAG_DBL)) t = TAG_INT;
                if (t == TAG_UTF8) t = TAG_INT;
                slot += add_tag(t);
            end
        end
        // A wide entry in the last slot ends the pool.
        void'(add_tag($urandom_range(0, 1) ? TAG_LONG : TAG_DBL));
        pool_size = target;
        file_bytes.push_back(target[15:8]);
        file_bytes.push_back(target[7:0]);
        flush_bytes();

        put_random(6);
        cnt = $urandom_range(0, 3);
        put16(cnt);
        put_random(cnt * 2);

        cnt = $urandom_range(1, 3);
        put16(cnt);
        for (int f = 0; f < cnt; f++) begin
            put_random(6);
            k = $urandom_range(0, 2);
            put16(k);
            add_skipped_attrs(k, 6);
        end

        cnt = $urandom_range(15, 19);
        put16(cnt);
        for (int m = 0; m < cnt; m++) begin
            put_random(6);
            k = $urandom_range(0, 3);
            put16(k);
            for (int a = 0; a < k; a++) begin
                nm = pick_name();
                put16(nm);
                if (nm != 0 && nm < pool_size && names_code(nm)) begin
                    put32($urandom());
                    put32($urandom());
                    len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
                    put32(len);
                    put_random(len);
                    len = $urandom_range(0, 2);
                    put16(len);
                    put_random(len * 8);
                    len = $urandom_range(0, 2);
                    put16(len);
                    add_skipped_attrs(len, 5);
                end else begin
                    len = $urandom_range(0, 10);
                    put32(len);
                    put_random(len);
                end
            end
        end

        k = $urandom_range(0, 2);
        put16(k);
        add_skipped_attrs(k, 8);
        // Bytes after the end of the class file are ignored.
        put_random(20);
        flush_bytes();
    endfunction

    function void reset_parser();
        phase = PH_MAGIC;
        field_pos = 0;
        field_acc = 0;
        pool_size = 0;
        pool_cur = 0;
        remaining = 0;
        grp_total = 0;
        grp_cur = 0;
        attr_total = 0;
        attr_cur = 0;
        inner_total = 0;
        inner_cur = 0;
        code_pos = 0;
        name_match = 0;
        foreach (code_flag[i]) code_flag[i] = 1'b0;
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch in %s: expected %h, got %h", what, want, got);
        errors++;
    endtask

    function bit quiet_stretch();
        return cycles >= 1500 && cycles < 1900;
    endfunction

    function bit rx_holding();
        return rx_cycles >= 500 && rx_cycles < 800;
    endfunction

    // Driver: the transaction is taken at the rising edge, the next byte is
    // offered at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full) begin
            parse_byte(i_data_byte);
            void'(file_bytes.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (file_bytes.size() > 0 &&
                     (quiet_stretch() || rx_holding() || $urandom_range(0, 99) >= 32)) begin
            i_push <= 1'b1;
            i_data_byte <= file_bytes[0];
        end else begin
            i_push <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_events.size() == 0) begin
                report("unexpected event kind", 0, o_kind);
            end else begin
                want = expected_events.pop_front();
                if (o_kind !== want.kind) report("kind", want.kind, o_kind);
                if (o_tag !== want.tag) report("tag", want.tag, o_tag);
                if (o_index !== want.index) report("index", want.index, o_index);
                if (o_offset !== want.offset) report("offset", want.offset, o_offset);
                if (o_value !== want.value) report("value", want.value, o_value);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            i_pop <= !rx_holding() && (quiet_stretch() || $urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        rx_cycles = 0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_data_byte = 8'h00;
        reset_parser();
        build_class_file();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (file_bytes.size() == 0);
        wait (expected_events.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
